/* rtl/hrd_pkg.sv */
// Package for the hit record decoder: record layout constants, field codes,
// the queue entry type and the timestamp decode function.
// Used by every module of the decoder; depends on nothing.
package hrd_pkg;

    localparam int ADC_CHANNELS = 32;
    localparam int POS_W        = 7;
    localparam int CHAN_W       = 5;
    localparam int KIND_W       = 3;
    localparam int VALUE_W      = 32;
    localparam int FLAGS_W      = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    localparam logic [POS_W-1:0] HDR_BYTES    = POS_W'(12);
    localparam logic [POS_W-1:0] ADC_END      = POS_W'(12 + 2 * ADC_CHANNELS);
    localparam logic [POS_W-1:0] REC_LEN_BASE = ADC_END;
    localparam logic [POS_W-1:0] REC_LEN_CO   = POS_W'(12 + 2 * ADC_CHANNELS + 4);

    localparam int TS_ABSENT_BIT    = 30;
    localparam int TS_REFERENCE_BIT = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_COINC_PRESENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TS_OFFSET     = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOST_CPU  = 3'd0,
        KIND_LOST_FPGA = 3'd1,
        KIND_TS0       = 3'd2,
        KIND_TS1       = 3'd3,
        KIND_ADC       = 3'd4,
        KIND_COINC     = 3'd5
    } field_kind_t;

    typedef struct packed {
        field_kind_t         kind;
        logic [CHAN_W-1:0]   chan;
        logic [VALUE_W-1:0]  raw;
        logic                last;
    } field_entry_t;

    // Bits 29:2 are Gray coded; the low two bits pass through unchanged.
    function automatic logic [VALUE_W-1:0] decode_stamp(
        input logic [VALUE_W-1:0] raw,
        input logic [CFG_DATA_W-1:0] offset
    );
        logic [27:0] g;
        logic [VALUE_W-1:0] bin;
        g = raw[29:2];
        g = g ^ (g >> 1);
        g = g ^ (g >> 2);
        g = g ^ (g >> 4);
        g = g ^ (g >> 8);
        g = g ^ (g >> 16);
        bin = {2'b00, g, raw[1:0]};
        return bin + {{(VALUE_W-CFG_DATA_W){1'b0}}, offset};
    endfunction

endpackage

/* rtl/hrd_in_if.sv */
// Byte input channel of the hit record decoder: valid, ready and one payload byte.
// Depends on nothing.
interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_hit;

    modport source (output valid, output data_byte, output start_of_hit, input ready);
    modport sink (input valid, input data_byte, input start_of_hit, output ready);
endinterface

/* rtl/hrd_out_if.sv */
// Field output channel of the hit record decoder: valid, ready and one decoded field.
// Depends on nothing.
interface hrd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  field_kind;
    logic [4:0]  channel;
    logic [31:0] value;
    logic [3:0]  hit_flags;
    logic        last_of_hit;

    modport source (output valid, output field_kind, output channel, output value,
                    output hit_flags, output last_of_hit, input ready);
    modport sink (input valid, input field_kind, input channel, input value,
                  input hit_flags, input last_of_hit, output ready);
endinterface

/* rtl/hit_record_decoder.sv */
// Hit record decoder top level: configuration registers, front end, queue and back end.
// Depends on hrd_pkg, hrd_in_if, hrd_out_if, hrd_front, hrd_queue and hrd_back.
//
// The decoder takes one payload byte per cycle and delivers one beat for every
// completed field of a hit record, queued when its last byte is accepted and then
// registered at the output. A four-entry queue separates the byte-position tracker
// from the timestamp decoder and output register, so a byte is accepted in every
// cycle while the queue has room, and a stalled output only holds the input back
// once the queue fills. Records are 76 bytes, or 80 with the coincidence word, and
// follow one another without any marker; start_of_hit restarts a record. The user
// must write configuration only while no beat is in flight; the block does not check.
module hit_record_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [hrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hrd_pkg::CFG_DATA_W-1:0] cfg_data,
    hrd_in_if.sink                        bytes,
    hrd_out_if.source                     fields
);
    import hrd_pkg::*;

    logic                  coinc_reg, coinc_next;
    logic [CFG_DATA_W-1:0] offset_reg, offset_next;
    logic                  push, pop, not_full, not_empty;
    field_entry_t          push_entry, head;

    always_comb
    begin
        coinc_next  = coinc_reg;
        offset_next = offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_COINC_PRESENT: coinc_next  = cfg_data[0];
                CFG_TS_OFFSET:     offset_next = cfg_data;
                default:           coinc_next  = coinc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coinc_reg  <= 1'b1;
            offset_reg <= CFG_DATA_W'(5);
        end
        else
        begin
            coinc_reg  <= coinc_next;
            offset_reg <= offset_next;
        end
    end

    assign bytes.ready = not_full;

    hrd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .coinc_present (coinc_reg),
        .byte_valid    (bytes.valid),
        .data_byte     (bytes.data_byte),
        .start_of_hit  (bytes.start_of_hit),
        .push_ok       (not_full),
        .push          (push),
        .push_entry    (push_entry)
    );

    hrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (not_full),
        .pop        (pop),
        .not_empty  (not_empty),
        .head       (head)
    );

    hrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ts_offset (offset_reg),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .fields    (fields)
    );

endmodule

/* rtl/hrd_front.sv */
// Front end of the hit record decoder: tracks the byte position, assembles
// little-endian fields and pushes each completed raw field into the queue.
// Depends on hrd_pkg.
module hrd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  coinc_present,
    input  logic                  byte_valid,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_hit,
    input  logic                  push_ok,
    output logic                  push,
    output hrd_pkg::field_entry_t push_entry
);
    import hrd_pkg::*;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] buf_reg, buf_next;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   rec_len;
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   adc_rel;
    logic [1:0]         off;
    logic [1:0]         size_m1;
    field_kind_t        kind;
    logic               accept;

    assign accept = byte_valid && push_ok;

    always_comb
    begin
        pos      = start_of_hit ? '0 : pos_reg;
        pos_inc  = pos + POS_W'(1);
        rec_len  = coinc_present ? REC_LEN_CO : REC_LEN_BASE;
        adc_rel  = pos - HDR_BYTES;
        kind     = KIND_COINC;
        start    = ADC_END;
        size_m1  = 2'd3;
        if (pos < POS_W'(2))
        begin
            kind = KIND_LOST_CPU;  start = POS_W'(0); size_m1 = 2'd1;
        end
        else if (pos < POS_W'(4))
        begin
            kind = KIND_LOST_FPGA; start = POS_W'(2); size_m1 = 2'd1;
        end
        else if (pos < POS_W'(8))
        begin
            kind = KIND_TS0;       start = POS_W'(4); size_m1 = 2'd3;
        end
        else if (pos < HDR_BYTES)
        begin
            kind = KIND_TS1;       start = POS_W'(8); size_m1 = 2'd3;
        end
        else if (pos < ADC_END)
        begin
            kind = KIND_ADC;       start = pos - POS_W'(adc_rel[0]); size_m1 = 2'd1;
        end
        off = 2'(pos - start);

        if (off == 2'd0)
            buf_next = {{(VALUE_W-8){1'b0}}, data_byte};
        else
            buf_next = buf_reg | ({{(VALUE_W-8){1'b0}}, data_byte} << {off, 3'b000});

        pos_next   = pos_reg;
        push       = 1'b0;
        push_entry.kind = kind;
        push_entry.chan = (kind == KIND_ADC) ? CHAN_W'(adc_rel >> 1) : '0;
        push_entry.raw  = buf_next;
        push_entry.last = (pos_inc == rec_len);
        if (accept)
        begin
            if (pos >= rec_len)
                pos_next = '0;
            else
            begin
                pos_next = (pos_inc >= rec_len) ? '0 : pos_inc;
                push     = (off == size_m1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            buf_reg <= '0;
        end
        else if (accept && (pos < rec_len))
        begin
            pos_reg <= pos_next;
            buf_reg <= buf_next;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* rtl/hrd_queue.sv */
// Short queue of raw fields between the front and back ends of the decoder.
// Depends on hrd_pkg.
module hrd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hrd_pkg::field_entry_t push_entry,
    output logic                  not_full,
    input  logic                  pop,
    output logic                  not_empty,
    output hrd_pkg::field_entry_t head
);
    import hrd_pkg::*;

    field_entry_t        mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign not_full  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/hrd_back.sv */
// Back end of the hit record decoder: decodes timestamps, builds the hit flags
// and holds each result in the output register until it is taken.
// Depends on hrd_pkg and hrd_out_if.
module hrd_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             ts_offset,
    input  logic                   not_empty,
    input  hrd_pkg::field_entry_t  head,
    output logic                   pop,
    hrd_out_if.source              fields
);
    import hrd_pkg::*;

    logic               valid_reg, valid_next;
    logic [1:0]         status_reg, status_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [CHAN_W-1:0]  chan_reg, chan_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;
    logic               last_reg, last_next;
    logic               present;

    assign pop     = not_empty && (!valid_reg || fields.ready);
    assign present = !head.raw[TS_ABSENT_BIT];

    always_comb
    begin
        valid_next  = valid_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        chan_next   = chan_reg;
        value_next  = value_reg;
        flags_next  = flags_reg;
        last_next   = last_reg;
        if (valid_reg && fields.ready)
            valid_next = 1'b0;
        if (pop)
        begin
            valid_next = 1'b1;
            kind_next  = KIND_W'(head.kind);
            chan_next  = head.chan;
            last_next  = head.last;
            value_next = head.raw;
            flags_next = '0;
            case (head.kind)
                KIND_TS0:
                begin
                    status_next = {head.raw[TS_REFERENCE_BIT], present};
                    value_next  = decode_stamp(head.raw, ts_offset);
                end
                KIND_TS1:
                begin
                    flags_next = {head.raw[TS_REFERENCE_BIT], status_reg[1], present,
                                  status_reg[0]};
                    value_next = decode_stamp(head.raw, ts_offset);
                end
                default:
                begin
                    value_next = head.raw;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            status_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        chan_reg  <= chan_next;
        value_reg <= value_next;
        flags_reg <= flags_next;
        last_reg  <= last_next;
    end

    assign fields.valid       = valid_reg;
    assign fields.field_kind  = kind_reg;
    assign fields.channel     = chan_reg;
    assign fields.value       = value_reg;
    assign fields.hit_flags   = flags_reg;
    assign fields.last_of_hit = last_reg;

endmodule

/* tb/hrd_field_checker.sv */
`timescale 1ns / 100ps
// Field checker for the hit record decoder: predicts every decoded field from the
// accepted bytes and configuration writes, and compares the output beats in order.
// Depends on hrd_pkg, hrd_in_if and hrd_out_if.
module hrd_field_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hrd_pkg::CFG_DATA_W-1:0] cfg_data,
    hrd_in_if                              byte_ch,
    hrd_out_if                             field_ch,
    output int                             fail_count,
    output int                             pending,
    output int                             fields_checked,
    output int                             records_done
);
    import hrd_pkg::*;

    typedef struct packed {
        field_kind_t         kind;
        logic [CHAN_W-1:0]   chan;
        logic [VALUE_W-1:0]  value;
        logic [FLAGS_W-1:0]  flags;
        logic                last;
    } field_beat_t;

    field_beat_t             expected_fields[$];
    logic                    coinc_on;
    logic [CFG_DATA_W-1:0]   stamp_offset;
    logic [POS_W-1:0]        rec_pos;
    logic [VALUE_W-1:0]      field_word;
    logic [1:0]              ts0_status;

    function automatic logic [VALUE_W-1:0] unscramble_stamp(
        input logic [VALUE_W-1:0] raw,
        input logic [CFG_DATA_W-1:0] offset
    );
        logic [27:0] g;
        logic [27:0] b;
        g = raw[29:2];
        b[27] = g[27];
        for (int i = 26; i >= 0; i--)
        begin
            b[i] = b[i + 1] ^ g[i];
        end
        return {2'b00, b, raw[1:0]} + VALUE_W'(offset);
    endfunction

    task automatic predict_field(input logic [7:0] d, input logic sync);
        int          rec_len;
        int          p;
        int          start;
        int          size;
        int          off;
        field_kind_t kind;
        field_beat_t beat;
        rec_len = int'(ADC_END) + (coinc_on ? 4 : 0);
        if (sync)
            rec_pos = '0;
        p = int'(rec_pos);
        if (p >= rec_len)
        begin
            rec_pos = '0;
            return;
        end
        if (p < 2)
        begin
            kind = KIND_LOST_CPU;
            start = 0;
            size = 2;
        end
        else if (p < 4)
        begin
            kind = KIND_LOST_FPGA;
            start = 2;
            size = 2;
        end
        else if (p < 8)
        begin
            kind = KIND_TS0;
            start = 4;
            size = 4;
        end
        else if (p < int'(HDR_BYTES))
        begin
            kind = KIND_TS1;
            start = 8;
            size = 4;
        end
        else if (p < int'(ADC_END))
        begin
            kind = KIND_ADC;
            start = p - ((p - int'(HDR_BYTES)) % 2);
            size = 2;
        end
        else
        begin
            kind = KIND_COINC;
            start = int'(ADC_END);
            size = 4;
        end
        off = p - start;
        if (off == 0)
            field_word = VALUE_W'(d);
        else
            field_word = field_word | (VALUE_W'(d) << (8 * (off % 4)));
        rec_pos = (p + 1 >= rec_len) ? '0 : POS_W'(p + 1);
        if (off + 1 != size)
            return;
        beat = '0;
        beat.kind = kind;
        beat.value = field_word;
        beat.last = (p + 1 == rec_len);
        case (kind)
            KIND_TS0:
            begin
                ts0_status = {field_word[TS_REFERENCE_BIT], ~field_word[TS_ABSENT_BIT]};
                beat.value = unscramble_stamp(field_word, stamp_offset);
            end
            KIND_TS1:
            begin
                beat.flags = {field_word[TS_REFERENCE_BIT], ts0_status[1],
                              ~field_word[TS_ABSENT_BIT], ts0_status[0]};
                beat.value = unscramble_stamp(field_word, stamp_offset);
            end
            KIND_ADC:
                beat.chan = CHAN_W'((start - int'(HDR_BYTES)) / 2);
            default:
                ;
        endcase
        expected_fields.insert(expected_fields.size(), beat);
    endtask

    function automatic int field_differs(
        input string name,
        input logic [VALUE_W-1:0] want,
        input logic [VALUE_W-1:0] got
    );
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        field_beat_t want;
        int          bad;
        if (!rst_n)
        begin
            coinc_on = 1'b1;
            stamp_offset = 8'd5;
            rec_pos = '0;
            field_word = '0;
            ts0_status = '0;
            expected_fields.delete();
            fail_count = 0;
            pending = 0;
            fields_checked = 0;
            records_done = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_COINC_PRESENT)
                    coinc_on = cfg_data[0];
                else if (cfg_index == CFG_TS_OFFSET)
                    stamp_offset = cfg_data;
            end
            if (byte_ch.valid && byte_ch.ready)
                predict_field(byte_ch.data_byte, byte_ch.start_of_hit);
            if (field_ch.valid && field_ch.ready)
            begin
                fields_checked++;
                if (expected_fields.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual kind %0d value 0x%0h",
                             $time, field_ch.field_kind, field_ch.value);
                    fail_count++;
                end
                else
                begin
                    want = expected_fields.pop_front();
                    bad = 0;
                    bad += field_differs("field_kind", VALUE_W'(want.kind),
                                         VALUE_W'(field_ch.field_kind));
                    bad += field_differs("channel", VALUE_W'(want.chan),
                                         VALUE_W'(field_ch.channel));
                    bad += field_differs("value", want.value, field_ch.value);
                    bad += field_differs("hit_flags", VALUE_W'(want.flags),
                                         VALUE_W'(field_ch.hit_flags));
                    bad += field_differs("last_of_hit", VALUE_W'(want.last),
                                         VALUE_W'(field_ch.last_of_hit));
                    if (bad != 0)
                        fail_count++;
                    if (want.last)
                        records_done++;
                end
            end
            pending = expected_fields.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Top of the hit record decoder testbench: clock, reset, byte stimulus, output stalls,
// configuration phases and the verdict. Depends on hrd_pkg, the two channel
// interfaces, hit_record_decoder and hrd_field_checker.
module testbench;
    import hrd_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int NUM_SETTINGS  = 10;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hrd_in_if  bytes_ch ();
    hrd_out_if fields_ch ();

    int fail_count;
    int pending;
    int fields_checked;
    int records_done;
    int bytes_sent;
    int cycles;
    int ready_hold;
    bit calm;

    hit_record_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bytes     (bytes_ch),
        .fields    (fields_ch)
    );

    hrd_field_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .byte_ch        (bytes_ch),
        .field_ch       (fields_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .fields_checked (fields_checked),
        .records_done   (records_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: run stopped at the cycle limit with %0d beats outstanding",
                     $time, pending);
            $display("** hit_record_decoder: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            fields_ch.ready <= calm || ($urandom_range(0, 2) != 0);
            ready_hold <= idle_gap();
        end
    end

    task automatic send_byte(input logic [7:0] d, input logic sync);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid <= 1'b1;
        bytes_ch.data_byte <= d;
        bytes_ch.start_of_hit <= sync;
        @(negedge clk);
        while (!bytes_ch.ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_record(input int len, input logic sync_first);
        logic sync;
        for (int i = 0; i < len; i++)
        begin
            sync = (i == 0) ? sync_first : ($urandom_range(0, 199) == 0);
            send_byte(8'($urandom_range(0, 255)), sync);
        end
    endtask

    task automatic wait_idle();
        bytes_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic coinc, input logic [CFG_DATA_W-1:0] offset);
        cfg_we <= 1'b1;
        cfg_index <= CFG_COINC_PRESENT;
        cfg_data <= CFG_DATA_W'(coinc);
        @(posedge clk);
        cfg_index <= CFG_TS_OFFSET;
        cfg_data <= offset;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [8:0] directed_seq [25];
        int         coinc_tab [NUM_SETTINGS];
        int         offset_tab [NUM_SETTINGS];
        int         rec_len;
        int         len;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        bytes_ch.valid = 1'b0;
        bytes_ch.data_byte = '0;
        bytes_ch.start_of_hit = 1'b0;
        fields_ch.ready = 1'b0;
        cycles = 0;
        ready_hold = 0;
        bytes_sent = 0;
        calm = 1'b0;

        // Header with all-zero and all-one fields, a partial field dropped by a
        // resynchronization, then a header with the largest Gray value and flags.
        directed_seq = '{
            9'h100, 9'h000, 9'h0ff, 9'h0ff,
            9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff,
            9'h000, 9'h000, 9'h000, 9'h000,
            9'h15a,
            9'h134, 9'h012, 9'h000, 9'h080,
            9'h0ff, 9'h0ff, 9'h0ff, 9'h03f,
            9'h003, 9'h000, 9'h000, 9'h0c0
        };
        coinc_tab = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 1};
        offset_tab = '{0, 255, 128, 255, 5, 0, 0, 0, 0, 0};
        for (int i = 6; i < NUM_SETTINGS; i++)
        begin
            offset_tab[i] = $urandom_range(0, 255);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_seq[i])
        begin
            send_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end

        for (int p = 0; p < NUM_SETTINGS; p++)
        begin
            wait_idle();
            calm = ($urandom_range(0, 3) == 0);
            write_config(coinc_tab[p][0], CFG_DATA_W'(offset_tab[p]));
            rec_len = int'(ADC_END) + (coinc_tab[p] != 0 ? 4 : 0);
            if (p == 2)
            begin
                // Stop inside the coincidence word so that the next setting,
                // with the word switched off, finds the position past the end.
                send_record(rec_len - 2, 1'b1);
            end
            else if (p == 3)
            begin
                send_record(rec_len + 1, 1'b0);
            end
            else
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, rec_len - 1) : rec_len;
                send_record(len, $urandom_range(0, 9) < 7);
            end
        end

        wait_idle();
        @(negedge clk);
        $display("Sent %0d bytes under %0d register settings after the directed header checks.",
                 bytes_sent, NUM_SETTINGS + 1);
        $display("Checked %0d field beats, %0d of them closing a hit record.",
                 fields_checked, records_done);
        if (fail_count == 0)
            $display("** hit_record_decoder: PASSED **");
        else
            $display("** hit_record_decoder: FAILED **");
        $finish;
    end

endmodule
